@@ rtl/chm_pkg.sv @@
package chm_pkg;

    localparam int unsigned DefBuckets  = 16;
    localparam int unsigned DefCapacity = 64;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_LOOKUP = 2'd2,
        REQ_OTHER  = 2'd3
    } req_type_t;

    typedef enum logic [2:0] {
        ST_ADDED   = 3'd0,
        ST_DUP     = 3'd1,
        ST_REMOVED = 3'd2,
        ST_MISSING = 3'd3,
        ST_FOUND   = 3'd4,
        ST_FULL    = 3'd5
    } status_t;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [30:0]        key;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        logic [2:0]         status;
        logic               hit;
        logic signed [31:0] found_value;
    } rsp_t;

endpackage

@@ rtl/chm_queue.sv @@
module chm_queue
    import chm_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  req_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output req_t out_data
);

    req_t data_reg [2];
    logic wr_ptr_reg, wr_ptr_next;
    logic rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = data_reg[rd_ptr_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            data_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

@@ rtl/chm_engine.sv @@
module chm_engine
    import chm_pkg::*;
#(
    parameter int unsigned BUCKETS  = DefBuckets,
    parameter int unsigned CAPACITY = DefCapacity
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req_data,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp_data
);

    localparam int PW = $clog2(CAPACITY + 1);
    localparam int NW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int CLRW = (BUCKETS > CAPACITY) ? $clog2(BUCKETS + 1) : $clog2(CAPACITY + 1);
    localparam logic [PW-1:0] NIL = PW'(CAPACITY);
    localparam logic [CLRW-1:0] CLR_END =
        CLRW'((BUCKETS > CAPACITY) ? BUCKETS : CAPACITY);
    localparam int SH = 31 + $clog2(BUCKETS);
    localparam logic [63:0] RECIP_W =
        ((64'd1 << SH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
    localparam logic [31:0] RECIP = RECIP_W[31:0];
    localparam logic [30:0] BKT_DIV = 31'(BUCKETS);

    typedef enum logic [7:0] {
        S_CLEAR = 8'b00000001,
        S_IDLE  = 8'b00000010,
        S_MOD   = 8'b00000100,
        S_HEAD  = 8'b00001000,
        S_READ  = 8'b00010000,
        S_CHECK = 8'b00100000,
        S_FREE  = 8'b01000000,
        S_DONE  = 8'b10000000
    } state_t;

    logic [PW-1:0] head_mem [BUCKETS];
    logic [30:0]   key_mem  [CAPACITY];
    logic [31:0]   val_mem  [CAPACITY];
    logic [PW-1:0] next_mem [CAPACITY];

    state_t state_reg, state_next;
    logic [CLRW-1:0] clr_reg, clr_next;
    req_t req_reg;
    logic [62:0] prod_reg;
    logic [BW-1:0] bkt_reg;
    logic [PW-1:0] cur_reg, cur_next;
    logic [PW-1:0] prev_reg, prev_next;
    logic [PW-1:0] free_reg, free_next;
    logic [PW-1:0] steps_reg, steps_next;
    logic [PW-1:0] head_rd_reg;
    logic [30:0]   key_rd_reg;
    logic [31:0]   val_rd_reg;
    logic [PW-1:0] next_rd_reg;
    logic [PW-1:0] free_nx_reg;
    rsp_t rsp_reg, rsp_next;
    logic rsp_valid_reg, rsp_valid_next;

    logic head_we;
    logic [BW-1:0] head_wa;
    logic [PW-1:0] head_wd;
    logic node_we;
    logic [NW-1:0] node_wa;
    logic next_we;
    logic [NW-1:0] next_wa;
    logic [PW-1:0] next_wd;
    logic [NW-1:0] rd_addr;
    logic [NW-1:0] free_addr;
    logic [30:0] quot;
    logic [30:0] rem_full;
    logic [BW-1:0] mod_bkt;

    // The bucket index comes from a reciprocal multiply registered at accept.
    assign quot      = 31'(prod_reg >> SH);
    assign rem_full  = req_reg.key - quot * BKT_DIV;
    assign mod_bkt   = BW'(rem_full);
    assign req_ready = (state_reg == S_IDLE) && !rsp_valid_reg;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;
    assign rd_addr   = NW'(cur_next);
    assign free_addr = NW'(free_reg);

    always_comb begin
        state_next = state_reg;
        clr_next = clr_reg;
        cur_next = cur_reg;
        prev_next = prev_reg;
        free_next = free_reg;
        steps_next = steps_reg;
        rsp_next = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        head_we = 1'b0;
        head_wa = bkt_reg;
        head_wd = '0;
        node_we = 1'b0;
        node_wa = free_addr;
        next_we = 1'b0;
        next_wa = '0;
        next_wd = '0;
        unique case (state_reg)
            S_CLEAR: begin
                if (clr_reg < CLRW'(BUCKETS)) begin
                    head_we = 1'b1;
                    head_wa = BW'(clr_reg);
                    head_wd = NIL;
                end
                if (clr_reg < CLRW'(CAPACITY)) begin
                    next_we = 1'b1;
                    next_wa = NW'(clr_reg);
                    next_wd = PW'(clr_reg) + PW'(1);
                end
                clr_next = clr_reg + CLRW'(1);
                if (clr_next == CLR_END) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (req_valid && req_ready) begin
                    state_next = S_MOD;
                end
            end
            S_MOD: begin
                state_next = S_HEAD;
            end
            S_HEAD: begin
                cur_next = head_rd_reg;
                prev_next = NIL;
                steps_next = '0;
                state_next = S_READ;
            end
            S_READ: begin
                state_next = S_CHECK;
            end
            S_CHECK: begin
                rsp_next.found_value = '0;
                if (cur_reg < NIL && key_rd_reg == req_reg.key) begin
                    rsp_next.hit = 1'b1;
                    state_next = S_DONE;
                    priority case (req_reg.req_type)
                        REQ_INSERT: rsp_next.status = ST_DUP;
                        REQ_REMOVE: begin
                            rsp_next.status = ST_REMOVED;
                            if (prev_reg < NIL) begin
                                next_we = 1'b1;
                                next_wa = NW'(prev_reg);
                                next_wd = next_rd_reg;
                            end else begin
                                head_we = 1'b1;
                                head_wd = next_rd_reg;
                            end
                            state_next = S_FREE;
                        end
                        default: begin
                            rsp_next.status = ST_FOUND;
                            rsp_next.found_value = val_rd_reg;
                        end
                    endcase
                end else if (cur_reg >= NIL || steps_reg == PW'(CAPACITY - 1)) begin
                    rsp_next.hit = 1'b0;
                    state_next = S_DONE;
                    if (req_reg.req_type == REQ_INSERT) begin
                        if (free_reg >= NIL) begin
                            rsp_next.status = ST_FULL;
                        end else begin
                            rsp_next.status = ST_ADDED;
                            node_we = 1'b1;
                            next_we = 1'b1;
                            next_wa = free_addr;
                            next_wd = head_rd_reg;
                            head_we = 1'b1;
                            head_wd = free_reg;
                            free_next = free_nx_reg;
                        end
                    end else begin
                        rsp_next.status = ST_MISSING;
                    end
                end else begin
                    prev_next = cur_reg;
                    cur_next = next_rd_reg;
                    steps_next = steps_reg + PW'(1);
                    state_next = S_READ;
                end
            end
            S_FREE: begin
                next_we = 1'b1;
                next_wa = NW'(cur_reg);
                next_wd = free_reg;
                free_next = cur_reg;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!rsp_valid_reg || rsp_ready) begin
                    rsp_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            free_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            free_reg <= free_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        prev_reg <= prev_next;
        steps_reg <= steps_next;
        rsp_reg <= rsp_next;
        if (req_valid && req_ready) begin
            req_reg <= req_data;
            prod_reg <= {32'd0, req_data.key} * {31'd0, RECIP};
        end
        if (state_reg == S_MOD) begin
            bkt_reg <= mod_bkt;
        end
    end

    always_ff @(posedge aclk) begin
        if (head_we) begin
            head_mem[head_wa] <= head_wd;
        end
        head_rd_reg <= head_mem[(state_reg == S_MOD) ? mod_bkt : bkt_reg];
    end

    always_ff @(posedge aclk) begin
        if (node_we) begin
            key_mem[node_wa] <= req_reg.key;
            val_mem[node_wa] <= req_reg.value;
        end
        key_rd_reg <= key_mem[rd_addr];
        val_rd_reg <= val_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (next_we) begin
            next_mem[next_wa] <= next_wd;
        end
        next_rd_reg <= next_mem[rd_addr];
        free_nx_reg <= next_mem[free_addr];
    end

endmodule

@@ rtl/chained_hash_map.sv @@
// Channel  Direction  Word
// s_       in         req_t: req_type, key, value
// m_       out        rsp_t: status, hit, found_value
//
// A request goes through MOD, HEAD, a READ and CHECK per chain node up to the
// match or chain end, FREE for a remove, then DONE, via the node memories.
// After reset a clearing pass first empties every bucket and frees every node.
// A two-word queue holds requests while the engine works or the result stalls.
module chained_hash_map
    import chm_pkg::*;
#(
    parameter int unsigned BUCKETS  = DefBuckets,
    parameter int unsigned CAPACITY = DefCapacity
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  req_t s_data,
    output logic m_valid,
    input  logic m_ready,
    output rsp_t m_data
);

    logic q_valid, q_ready;
    req_t q_data;

    chm_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_valid), .in_ready(s_ready), .in_data(s_data),
        .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
    );

    chm_engine #(.BUCKETS(BUCKETS), .CAPACITY(CAPACITY)) u_engine (
        .aclk(aclk), .aresetn(aresetn),
        .req_valid(q_valid), .req_ready(q_ready), .req_data(q_data),
        .rsp_valid(m_valid), .rsp_ready(m_ready), .rsp_data(m_data)
    );

endmodule

@@ rtl/chm_checker.sv @@
module chm_checker
    import chm_pkg::*;
(
    input logic aclk,
    input logic aresetn,
    input logic m_valid,
    input logic m_ready,
    input rsp_t m_data
);

    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.status <= ST_FULL)
        else $error("status out of range");

    a_hit_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.hit == (m_data.status == ST_DUP ||
            m_data.status == ST_REMOVED || m_data.status == ST_FOUND))
        else $error("hit disagrees with status");

    a_zero_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_FOUND |-> m_data.found_value == '0)
        else $error("found_value nonzero without a lookup hit");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind chained_hash_map chm_checker u_chm_checker (
    .aclk(aclk), .aresetn(aresetn),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);

@@ dv/chained_hash_map_tb.sv @@
module chained_hash_map_tb;
    import chm_pkg::*;

    localparam int NB = DefBuckets;
    localparam int NC = DefCapacity;
    localparam int LIMIT = 2000000;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    req_t s_data;
    logic m_valid;
    logic m_ready;
    rsp_t m_data;

    chained_hash_map u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    int unsigned bucket_head [NB];
    logic [30:0] node_key [NC];
    logic [31:0] node_val [NC];
    int unsigned node_next [NC];
    int unsigned free_head;
    int unsigned used_count;

    req_t pending_reqs [$];
    rsp_t expected_rsps [$];
    logic [30:0] key_pool [48];
    int errors;
    int cycles;

    function automatic void map_reset();
        for (int i = 0; i < NB; i++) bucket_head[i] = NC;
        for (int i = 0; i < NC; i++) node_next[i] = i + 1;
        free_head = 0;
        used_count = 0;
    endfunction

    function automatic rsp_t map_apply(req_t rq);
        rsp_t rs;
        int unsigned b;
        int unsigned cur;
        int unsigned prev;
        int unsigned node;
        int unsigned pred;
        int unsigned n;
        b = rq.key % NB;
        cur = bucket_head[b];
        prev = NC;
        node = NC;
        pred = NC;
        for (int s = 0; s < NC; s++) begin
            if (cur >= NC) break;
            if (node_key[cur] == rq.key) begin
                node = cur;
                pred = prev;
                break;
            end
            prev = cur;
            cur = node_next[cur];
        end
        rs.hit = (node < NC);
        rs.found_value = '0;
        if (rq.req_type == REQ_INSERT) begin
            if (rs.hit) begin
                rs.status = ST_DUP;
            end else if (free_head >= NC) begin
                rs.status = ST_FULL;
            end else begin
                n = free_head;
                free_head = node_next[n];
                node_key[n] = rq.key;
                node_val[n] = rq.value;
                node_next[n] = bucket_head[b];
                bucket_head[b] = n;
                used_count++;
                rs.status = ST_ADDED;
            end
        end else if (rq.req_type == REQ_REMOVE) begin
            if (rs.hit) begin
                if (pred < NC) node_next[pred] = node_next[node];
                else bucket_head[b] = node_next[node];
                node_next[node] = free_head;
                free_head = node;
                if (used_count > 0) used_count--;
                rs.status = ST_REMOVED;
            end else begin
                rs.status = ST_MISSING;
            end
        end else begin
            if (rs.hit) begin
                rs.status = ST_FOUND;
                rs.found_value = node_val[node];
            end else begin
                rs.status = ST_MISSING;
            end
        end
        return rs;
    endfunction

    function automatic bit idle_now();
        if (cycles > 20000 && cycles < 40000) return 1'b0;
        return $urandom_range(0, 99) < 20;
    endfunction

    function automatic void queue_req(req_type_t op, logic [30:0] k, logic [31:0] v);
        req_t rq;
        rq.req_type = op;
        rq.key = k;
        rq.value = v;
        pending_reqs.push_back(rq);
    endfunction

    function automatic logic [31:0] rnd_val();
        return $urandom;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data <= '0;
        end else begin
            if (s_valid && s_ready) expected_rsps.push_back(map_apply(s_data));
            if (!s_valid || s_ready) begin
                if (pending_reqs.size() > 0 && !idle_now()) begin
                    s_valid <= 1'b1;
                    s_data <= pending_reqs.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= !idle_now();
            if (m_valid && m_ready) begin
                if (expected_rsps.size() == 0) begin
                    $error("unexpected word: status %0d", m_data.status);
                    errors++;
                end else begin
                    rsp_t ex;
                    ex = expected_rsps.pop_front();
                    if (m_data.status !== ex.status) begin
                        $error("status expected %0d actual %0d", ex.status, m_data.status);
                        errors++;
                    end
                    if (m_data.hit !== ex.hit) begin
                        $error("hit expected %0d actual %0d", ex.hit, m_data.hit);
                        errors++;
                    end
                    if (m_data.found_value !== ex.found_value) begin
                        $error("found_value expected %0d actual %0d",
                               ex.found_value, m_data.found_value);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        int total;
        int mode;
        logic [30:0] k;
        logic [30:0] fill_keys [$];
        errors = 0;
        cycles = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        map_reset();
        for (int i = 0; i < 48; i++) key_pool[i] = 31'($urandom);

        queue_req(REQ_LOOKUP, 31'd0, 32'd0);
        queue_req(REQ_INSERT, 31'd0, 32'h7FFF_FFFF);
        queue_req(REQ_INSERT, 31'h7FFF_FFFF, 32'h8000_0000);
        queue_req(REQ_INSERT, 31'd16, 32'hFFFF_FFFF);
        queue_req(REQ_INSERT, 31'd32, 32'd1);
        queue_req(REQ_INSERT, 31'd0, 32'd5);
        queue_req(REQ_LOOKUP, 31'd0, 32'hFFFF_FFFF);
        queue_req(REQ_LOOKUP, 31'h7FFF_FFFF, 32'd0);
        queue_req(REQ_OTHER, 31'd16, 32'd0);
        queue_req(REQ_OTHER, 31'd48, 32'd0);
        queue_req(REQ_REMOVE, 31'd16, 32'd0);
        queue_req(REQ_LOOKUP, 31'd32, 32'd0);
        queue_req(REQ_REMOVE, 31'd32, 32'd0);
        queue_req(REQ_REMOVE, 31'd0, 32'd0);
        queue_req(REQ_REMOVE, 31'd0, 32'd0);
        queue_req(REQ_LOOKUP, 31'd16, 32'd0);
        queue_req(REQ_REMOVE, 31'h7FFF_FFFF, 32'd0);
        queue_req(REQ_INSERT, 31'd16, 32'd7);

        total = pending_reqs.size();
        while (total < 1350) begin
            mode = $urandom_range(0, 9);
            if (mode < 2) begin
                // Fill the map past capacity, then drain it in reverse.
                fill_keys.delete();
                for (int i = 0; i < 70; i++) begin
                    k = 31'($urandom);
                    if (i % 3 == 0) k = {k[30:4], 4'd5};
                    fill_keys.push_back(k);
                    queue_req(REQ_INSERT, k, rnd_val());
                end
                for (int i = 69; i >= 0; i--) begin
                    if (i % 4 == 0) queue_req(REQ_LOOKUP, fill_keys[i], rnd_val());
                    queue_req(REQ_REMOVE, fill_keys[i], rnd_val());
                end
                total += 158;
            end else begin
                for (int i = 0; i < 40; i++) begin
                    k = key_pool[$urandom_range(0, 47)];
                    mode = $urandom_range(0, 99);
                    if (mode < 5) queue_req(REQ_LOOKUP, 31'($urandom), rnd_val());
                    else if (mode < 10) queue_req(REQ_OTHER, k, rnd_val());
                    else if (mode < 50) queue_req(REQ_INSERT, k, rnd_val());
                    else if (mode < 75) queue_req(REQ_REMOVE, k, rnd_val());
                    else queue_req(REQ_LOOKUP, k, rnd_val());
                end
                total += 40;
            end
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        while (pending_reqs.size() > 0 || s_valid || expected_rsps.size() > 0)
            @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (errors == 0 && expected_rsps.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
